/* rtl/demst_pkg.sv */
// ----------------------------------------------------------------------------
// demst_pkg: shared types and constants for the Euclidean MST block
// Index widths, length limits and controller/datapath command structs.
// ----------------------------------------------------------------------------
package demst_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int IN_COORD_W = 16;
  localparam int OUT_IDX_W  = 6;
  localparam int LEN_W      = 25;
  localparam int SUM_W      = 31;
  localparam int SQ_W       = 50;
  localparam int ROOT_W     = 26;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_point;  // write accepted point into the point store
    logic clear_load;   // restart the load count
    logic init_start;   // begin a tree: newest = 0, pending = n-1
    logic init_entry;   // write one pending-list entry at the sweep index
    logic scan_start;   // reset scan index and running minimum
    logic scan_read;    // issue reads for the current scan index
    logic scan_eval;    // evaluate returned data for the previous index
    logic root_start;   // launch the square-root unit on the best distance
    logic commit;       // retire chosen entry from the pending count
    logic move_read;    // read last entry for the swap
    logic move_write;   // write it into the chosen slot
  } demst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few_points;   // fewer than two points in the set
    logic init_done;    // sweep index reached the last entry
    logic scan_last;    // read index is the last pending entry
    logic root_done;    // square root result is ready
    logic list_empty;   // no pending entries after commit
  } demst_stat_t;

endpackage

/* rtl/demst_ram.sv */
// ----------------------------------------------------------------------------
// demst_ram: generic single-port-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module demst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/demst_sqrt.sv */
// ----------------------------------------------------------------------------
// demst_sqrt: iterative rounded square root with saturation
// One result bit per cycle; rounds half up, saturates to the length field.
// ----------------------------------------------------------------------------
module demst_sqrt #(
  parameter int FRAC_BITS = demst_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [demst_pkg::SQ_W-1:0]    sq,
  output logic                          done,
  output logic [demst_pkg::LEN_W-1:0]   root
);

  localparam int RW     = demst_pkg::ROOT_W;
  localparam int OPW    = 2 * RW;
  localparam int LIM_SH = demst_pkg::SQ_W - 2 * FRAC_BITS;
  localparam int CNT_W  = $clog2(RW + 1);

  logic [OPW-1:0]   rem;
  logic [OPW-1:0]   src;
  logic [RW-1:0]    q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             sat;

  logic [OPW+1:0] trial;
  logic [OPW+1:0] rem_sh;
  logic [RW:0]    rnd;

  // Restoring square root, two radicand bits per step.
  assign rem_sh = {rem, src[OPW-1 -: 2]};
  assign trial  = rem_sh - {{(OPW-RW){1'b0}}, q, 2'b01};
  assign rnd    = {1'b0, q} + ((rem > {{(OPW-RW){1'b0}}, q}) ? (RW+1)'(1) : (RW+1)'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RW);
        rem  <= '0;
        q    <= '0;
        src  <= OPW'(sq) << (2 * FRAC_BITS);
        sat  <= (sq >> LIM_SH) != '0;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (sat || rnd > (RW+1)'(demst_pkg::LEN_MAX)) begin
            root <= demst_pkg::LEN_MAX;
          end else begin
            root <= rnd[demst_pkg::LEN_W-1:0];
          end
        end else begin
          cnt <= cnt - CNT_W'(1);
          src <= src << 2;
          if (!trial[OPW+1]) begin
            rem <= trial[OPW-1:0];
            q   <= {q[RW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[OPW-1:0];
            q   <= {q[RW-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

/* rtl/demst_datapath.sv */
// ----------------------------------------------------------------------------
// demst_datapath: point store, pending list and distance evaluation
// Holds memories, scan minimum, running sums and the result register.
// ----------------------------------------------------------------------------
module demst_datapath #(
  parameter int MAX_POINTS = demst_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = demst_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = demst_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  demst_pkg::demst_cmd_t               cmd,
  output demst_pkg::demst_stat_t              stat,
  input  logic [demst_pkg::IN_COORD_W-1:0]    in_x,
  input  logic [demst_pkg::IN_COORD_W-1:0]    in_y,
  output logic [demst_pkg::OUT_IDX_W-1:0]     res_from,
  output logic [demst_pkg::OUT_IDX_W-1:0]     res_to,
  output logic [demst_pkg::LEN_W-1:0]         res_len,
  output logic [demst_pkg::SUM_W-1:0]         res_sum
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int SQW = 2 * COORD_BITS + 1;
  localparam int PW  = SQW + 2 * AW;

  logic [CW-1:0] loaded;
  logic [CW-1:0] pcount;
  logic [AW-1:0] newest;
  logic [CW-1:0] idx;       // read index of scan / init sweep
  logic [CW-1:0] eidx;      // index whose data returns this cycle
  logic [AW-1:0] sel;
  logic [SQW-1:0] sel_sq;
  logic [AW-1:0] sel_par;
  logic [AW-1:0] sel_tgt;
  logic           have_sel;
  logic [2*COORD_BITS-1:0] nv_pt;
  logic [demst_pkg::SUM_W:0] sum_ext;

  // Point store.
  logic                    pt_we;
  logic [AW-1:0]           pt_raddr;
  logic [2*COORD_BITS-1:0] pt_rdata;

  // Pending list: {best_sq, parent, target}.
  logic          pl_we;
  logic [AW-1:0] pl_waddr;
  logic [PW-1:0] pl_wdata;
  logic [AW-1:0] pl_raddr;
  logic [PW-1:0] pl_rdata;

  assign pt_we = cmd.store_point && (loaded < CW'(MAX_POINTS));

  demst_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_pts (
    .clk   (clk),
    .we    (pt_we),
    .waddr (loaded[AW-1:0]),
    .wdata ({COORD_BITS'(in_y), COORD_BITS'(in_x)}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  demst_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pend (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // Both memories are read in sequence during a scan: the pending entry's
  // target is needed to address the point store, so reads are two-phase.
  // Phase A reads the pending entry; phase B uses its target for the point.
  logic [PW-1:0] pe_hold;
  logic          phase_b;

  logic [SQW-1:0] e_sq;
  logic [AW-1:0]  e_par;
  logic [AW-1:0]  e_tgt;
  assign e_sq  = pe_hold[PW-1 -: SQW];
  assign e_par = pe_hold[2*AW-1:AW];
  assign e_tgt = pe_hold[AW-1:0];

  logic [COORD_BITS-1:0] ax, ay, bx, by, dx, dy;
  assign ax = nv_pt[COORD_BITS-1:0];
  assign ay = nv_pt[2*COORD_BITS-1:COORD_BITS];
  assign bx = pt_rdata[COORD_BITS-1:0];
  assign by = pt_rdata[2*COORD_BITS-1:COORD_BITS];
  assign dx = (ax > bx) ? ax - bx : bx - ax;
  assign dy = (ay > by) ? ay - by : by - ay;

  logic [2*COORD_BITS-1:0] dxx, dyy;
  logic [SQW-1:0] d_sq, new_sq;
  logic [AW-1:0]  new_par;
  logic           upd;
  assign dxx     = dx * dx;
  assign dyy     = dy * dy;
  assign d_sq    = SQW'(dxx) + SQW'(dyy);
  assign upd     = d_sq < e_sq;
  assign new_sq  = upd ? d_sq : e_sq;
  assign new_par = upd ? newest : e_par;

  // Memory address and write muxing.
  always_comb begin
    pl_we    = 1'b0;
    pl_waddr = idx[AW-1:0];
    pl_wdata = '0;
    pl_raddr = idx[AW-1:0];
    pt_raddr = e_tgt;
    if (phase_b) begin
      pt_raddr = pl_rdata[AW-1:0];
    end
    if (cmd.init_entry) begin
      pl_we    = 1'b1;
      pl_wdata = {{SQW{1'b1}}, {AW{1'b0}}, AW'(idx + CW'(1))};
    end else if (cmd.scan_eval) begin
      pl_we    = 1'b1;
      pl_waddr = eidx[AW-1:0];
      pl_wdata = {new_sq, new_par, e_tgt};
    end else if (cmd.move_read) begin
      pl_raddr = AW'(pcount - CW'(1));
    end else if (cmd.move_write) begin
      pl_we    = 1'b1;
      pl_waddr = sel;
      pl_wdata = pl_rdata;
    end
    // fetch the newest vertex so the next scan start can latch it
    if (cmd.init_entry || cmd.move_write) begin
      pt_raddr = newest;
    end
  end

  logic [demst_pkg::LEN_W-1:0] root;
  logic                        root_done;

  demst_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .sq    (demst_pkg::SQ_W'(sel_sq)),
    .done  (root_done),
    .root  (root)
  );

  assign sum_ext = {1'b0, res_sum} + (demst_pkg::SUM_W+1)'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded  <= '0;
      pcount  <= '0;
      newest  <= '0;
      phase_b <= 1'b0;
      res_sum <= '0;
    end else begin
      if (pt_we) begin
        loaded <= loaded + CW'(1);
      end
      if (cmd.clear_load) begin
        loaded <= '0;
      end
      if (cmd.init_start) begin
        newest  <= '0;
        idx     <= '0;
        pcount  <= loaded - CW'(1);
        res_sum <= '0;
      end
      if (cmd.init_entry) begin
        idx <= idx + CW'(1);
      end
      if (cmd.scan_start) begin
        idx      <= '0;
        have_sel <= 1'b0;
        phase_b  <= 1'b0;
        nv_pt    <= pt_rdata;
      end
      if (cmd.scan_read) begin
        // phase A: pending data arrives next cycle
        phase_b <= 1'b1;
        eidx    <= idx;
        idx     <= idx + CW'(1);
      end
      if (phase_b && !cmd.scan_eval) begin
        pe_hold <= pl_rdata;
        phase_b <= 1'b0;
      end
      if (cmd.scan_eval) begin
        if (!have_sel || new_sq < sel_sq) begin
          sel     <= eidx[AW-1:0];
          sel_sq  <= new_sq;
          sel_par <= new_par;
          sel_tgt <= e_tgt;
        end
        have_sel <= 1'b1;
      end
      if (root_done) begin
        res_len <= root;
        res_sum <= sum_ext[demst_pkg::SUM_W] ? demst_pkg::SUM_MAX
                                             : sum_ext[demst_pkg::SUM_W-1:0];
        res_from <= demst_pkg::OUT_IDX_W'(sel_par);
        res_to   <= demst_pkg::OUT_IDX_W'(sel_tgt);
      end
      if (cmd.root_start) begin
        newest <= sel_tgt;
      end
      if (cmd.commit) begin
        pcount <= pcount - CW'(1);
      end
    end
  end

  assign stat.few_points = loaded <= CW'(1);
  assign stat.init_done  = idx == pcount - CW'(1);
  assign stat.scan_last  = eidx == pcount - CW'(1);
  assign stat.root_done  = root_done;
  assign stat.list_empty = pcount == CW'(1);

endmodule

/* rtl/demst_ctrl.sv */
// ----------------------------------------------------------------------------
// demst_ctrl: sequencer for load, Prim scan, square root and result handoff
// Drives datapath commands and the stream handshakes.
// ----------------------------------------------------------------------------
module demst_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_edge_valid,
  output logic                    out_last,
  output demst_pkg::demst_cmd_t   cmd,
  input  demst_pkg::demst_stat_t  stat
);

  typedef enum logic [10:0] {
    S_LOAD  = 11'b000_0000_0001,
    S_INIT  = 11'b000_0000_0010,
    S_PREP  = 11'b000_0000_0100,
    S_RDA   = 11'b000_0000_1000,
    S_RDB   = 11'b000_0001_0000,
    S_EVAL  = 11'b000_0010_0000,
    S_ROOT  = 11'b000_0100_0000,
    S_WAIT  = 11'b000_1000_0000,
    S_OUT   = 11'b001_0000_0000,
    S_MOVE  = 11'b010_0000_0000,
    S_SINGLE = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   in_xfer;
  logic   last_res;
  logic   last_res_next;

  assign in_xfer = in_valid && in_ready;
  assign in_ready = state == S_LOAD;

  always_comb begin
    state_next    = state;
    last_res_next = last_res;
    cmd           = '0;
    out_valid     = 1'b0;
    out_edge_valid = 1'b1;
    out_last      = last_res;
    unique case (state)
      S_LOAD: begin
        if (in_xfer) begin
          cmd.store_point = 1'b1;
          if (in_last) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        // point store read of vertex 0 lands during the sweep
        if (stat.few_points) begin
          cmd.clear_load = 1'b1;
          state_next = S_SINGLE;
        end else begin
          cmd.init_start = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.init_entry = 1'b1;
        if (stat.init_done) begin
          cmd.clear_load = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        // newest vertex coordinates were read at init (first scan) or in S_MOVE
        cmd.scan_start = 1'b1;
        state_next = S_RDA;
      end
      S_RDA: begin
        cmd.scan_read = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.scan_eval = 1'b1;
        if (stat.scan_last) begin
          state_next = S_WAIT;
        end else begin
          state_next = S_RDA;
        end
      end
      S_WAIT: begin
        if (!last_res) begin
          cmd.root_start = 1'b1;
          last_res_next = 1'b1;
        end else if (stat.root_done) begin
          last_res_next = stat.list_empty;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.commit = 1'b1;
          if (last_res) begin
            last_res_next = 1'b0;
            state_next = S_LOAD;
          end else begin
            cmd.move_read = 1'b1;
            state_next = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        cmd.move_write = 1'b1;
        state_next = S_ROOT;
      end
      S_SINGLE: begin
        out_valid      = 1'b1;
        out_edge_valid = 1'b0;
        out_last       = 1'b1;
        if (out_ready) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      last_res <= 1'b0;
    end else begin
      state    <= state_next;
      last_res <= last_res_next;
    end
  end

endmodule

/* rtl/dense_euclidean_mst_prim.sv */
// ----------------------------------------------------------------------------
// Loading accepts one point per cycle; for a set of N points each tree step then
// reads and evaluates every pending vertex in turn (states RDA, RDB, EVAL),
// then runs the square root and hands the edge off, which m_tready can stall.
// Throughput: one point set at a time; the pending-list scan sets the rate.
// Reset (rst, synchronous, active high) empties the point set and idles.
// ----------------------------------------------------------------------------
// dense_euclidean_mst_prim: dense Prim minimum spanning tree over planar points
// Streams points in, streams tree edges out with fixed-point lengths.
// ----------------------------------------------------------------------------
module dense_euclidean_mst_prim #(
  parameter int MAX_POINTS = demst_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = demst_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = demst_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // point_x[15:0], point_y[31:16]
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // from_point[5:0], to_point[11:6],
                                 // edge_length[36:12], total_length[67:37],
                                 // edge_valid[68], zero fill [71:69]
  output logic        m_tlast    // last_edge
);

  demst_pkg::demst_cmd_t  cmd;
  demst_pkg::demst_stat_t stat;

  logic [demst_pkg::OUT_IDX_W-1:0] res_from, res_to;
  logic [demst_pkg::LEN_W-1:0]     res_len;
  logic [demst_pkg::SUM_W-1:0]     res_sum;
  logic                            edge_ok;

  demst_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_last        (s_tlast),
    .in_ready       (s_tready),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_edge_valid (edge_ok),
    .out_last       (m_tlast),
    .cmd            (cmd),
    .stat           (stat)
  );

  demst_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_x     (s_tdata[15:0]),
    .in_y     (s_tdata[31:16]),
    .res_from (res_from),
    .res_to   (res_to),
    .res_len  (res_len),
    .res_sum  (res_sum)
  );

  assign m_tdata = edge_ok ? {3'b000, 1'b1, res_sum, res_len, res_to, res_from}
                           : 72'd0;

endmodule
